// ----- rtl/absmax_int8_quantizer_assert.svh -----
// Assertion macros for the absmax INT8 quantizer.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ABSMAX_INT8_QUANTIZER_ASSERT_SVH
`define ABSMAX_INT8_QUANTIZER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ABSQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("absq assertion failed");

// Next-cycle implication, disabled in reset.
`define ABSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("absq assertion failed");

`endif

// ----- rtl/absq_pkg.sv -----
// Shared types and constants for the absmax INT8 quantizer.
// No dependencies.
`default_nettype none
package absq_pkg;

    localparam logic KIND_MEASURE  = 1'b0;
    localparam logic KIND_QUANTIZE = 1'b1;

    localparam logic [16:0] ONE_Q412 = 17'd4096;
    localparam logic [6:0]  QMAX     = 7'd127;

    // One queued work item between front and back.
    typedef struct packed {
        logic        kind;
        logic        neg;
        logic        last;
        logic [16:0] mag;
        logic [16:0] divisor;
    } absq_entry_t;

endpackage
`default_nettype wire

// ----- rtl/absq_front.sv -----
// Front end: accepts items, tracks the running maximum and the divisor,
// and queues scale reports and quantize jobs. Depends on absq_pkg.
`default_nettype none
module absq_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [15:0]           s_axis_tdata,   // [15:0] value
    input  wire logic                  s_axis_tuser,   // [0] kind
    input  wire logic                  s_axis_tlast,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output absq_pkg::absq_entry_t      push_data
);

    logic [16:0] run_max_reg;
    logic [16:0] run_max_next;
    logic [16:0] div_reg;
    logic [16:0] div_next;
    logic [16:0] mag;
    logic [16:0] new_max;
    logic [16:0] latched;
    logic        accept;

    assign s_axis_tready = push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_axis_tdata[15])
            mag = 17'h10000 - {1'b0, s_axis_tdata};
        else
            mag = {1'b0, s_axis_tdata};
        new_max = (mag > run_max_reg) ? mag : run_max_reg;
        latched = (new_max == 17'd0) ? absq_pkg::ONE_Q412 : new_max;
    end

    always_comb
    begin
        run_max_next = run_max_reg;
        div_next     = div_reg;
        if (accept)
        begin
            if (s_axis_tuser == absq_pkg::KIND_MEASURE)
            begin
                run_max_next = new_max;
                if (s_axis_tlast)
                    div_next = latched;
            end
            else if (s_axis_tlast)
            begin
                run_max_next = 17'd0;
            end
        end
    end

    // Non-last measure items produce nothing downstream.
    assign push_valid = s_axis_tvalid &&
                        ((s_axis_tuser == absq_pkg::KIND_QUANTIZE) || s_axis_tlast);

    always_comb
    begin
        push_data.kind    = s_axis_tuser;
        push_data.neg     = s_axis_tdata[15];
        push_data.last    = s_axis_tlast;
        push_data.mag     = mag;
        push_data.divisor = (s_axis_tuser == absq_pkg::KIND_MEASURE) ? latched : div_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_max_reg <= 17'd0;
            div_reg     <= absq_pkg::ONE_Q412;
        end
        else
        begin
            run_max_reg <= run_max_next;
            div_reg     <= div_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/absq_queue.sv -----
// Small FIFO of work items between front and back.
// Depends on absq_pkg.
`default_nettype none
module absq_queue #(
    parameter int AW = 2
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire absq_pkg::absq_entry_t push_data,
    output logic                       pop_valid,
    input  wire logic                  pop_ready,
    output absq_pkg::absq_entry_t      pop_data
);

    localparam int DEPTH = 2 ** AW;

    absq_pkg::absq_entry_t mem [DEPTH];
    logic [AW:0] wr_ptr_reg;
    logic [AW:0] rd_ptr_reg;
    logic        empty;
    logic        full;
    logic        do_push;
    logic        do_pop;

    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                        (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_data   = mem[rd_ptr_reg[AW-1:0]];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop_ready && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg[AW-1:0]] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/absq_back.sv -----
// Back end: takes queued items, runs the 8-step restoring division for
// quantize jobs and holds the result register. Depends on absq_pkg.
`default_nettype none
module absq_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire absq_pkg::absq_entry_t pop_data,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // [7:0] quantized, [23:8] abs_max
    output logic                       m_axis_tuser,   // [0] result_kind
    output logic                       m_axis_tlast    // end_of_tensor
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [24:0] rem_reg;
    logic [17:0] den_reg;
    logic [7:0]  quo_reg;
    logic [2:0]  step_reg;
    logic        kind_reg;
    logic        neg_reg;
    logic        last_reg;
    logic [15:0] div_reg;

    logic        out_valid_reg;
    logic [23:0] out_data_reg;
    logic        out_user_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        take;
    logic [24:0] trial;
    logic        fits;
    logic [24:0] numer;
    logic [6:0]  code_mag;
    logic [7:0]  code;

    assign pop_ready = (state_reg == ST_IDLE);
    assign take      = pop_valid && pop_ready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // 254*mag + d, the numerator of (2*mag*127 + d) / (2*d).
    assign numer = ({pop_data.mag, 8'd0} - {7'd0, pop_data.mag, 1'b0}) +
                   {8'd0, pop_data.divisor};

    assign trial = {7'd0, den_reg} << step_reg;
    assign fits  = (rem_reg >= trial);

    // Quotient of 128 or more saturates.
    assign code_mag = quo_reg[7] ? absq_pkg::QMAX : quo_reg[6:0];
    assign code     = neg_reg ? (8'd0 - {1'b0, code_mag}) : {1'b0, code_mag};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = (pop_data.kind == absq_pkg::KIND_QUANTIZE) ? ST_CALC : ST_SEND;
            end
            ST_CALC:
            begin
                if (step_reg == 3'd0)
                    state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rem_reg  <= numer;
            den_reg  <= {pop_data.divisor, 1'b0};
            quo_reg  <= 8'd0;
            step_reg <= 3'd7;
            kind_reg <= pop_data.kind;
            neg_reg  <= pop_data.neg;
            last_reg <= pop_data.last;
            div_reg  <= pop_data.divisor[15:0];
        end
        else if (state_reg == ST_CALC)
        begin
            if (fits)
            begin
                rem_reg           <= rem_reg - trial;
                quo_reg[step_reg] <= 1'b1;
            end
            step_reg <= step_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_SEND) && out_free)
        begin
            out_user_reg <= kind_reg;
            out_last_reg <= last_reg;
            if (kind_reg == absq_pkg::KIND_QUANTIZE)
                out_data_reg <= {div_reg, code};
            else
                out_data_reg <= {div_reg, 8'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_SEND) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/absmax_int8_quantizer.sv -----
// Symmetric absmax INT8 quantizer, top level: front, queue and back.
// Depends on absq_pkg, absq_front, absq_queue, absq_back and the assert header.
//
// A tensor streams in twice. Measure items (tuser 0) update the running
// maximum magnitude; the last one latches it as the divisor (4096 if all
// zero) and yields a scale report. Quantize items (tuser 1) yield
// round(value*127/divisor) clamped to +-127; the last one clears the maximum.
// The front takes one item per cycle while the queue has room. The back takes
// one item at a time: setup, eight restoring-division steps and result load
// per quantize item, setup and result load per scale report.
`default_nettype none
`include "absmax_int8_quantizer_assert.svh"
module absmax_int8_quantizer #(
    parameter int QUEUE_AW = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] value
    input  wire logic        s_axis_tuser,   // [0] kind
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [7:0] quantized, [23:8] abs_max
    output logic             m_axis_tuser,   // [0] result_kind
    output logic             m_axis_tlast    // end_of_tensor
);

    logic                  push_valid;
    logic                  push_ready;
    absq_pkg::absq_entry_t push_data;
    logic                  pop_valid;
    logic                  pop_ready;
    absq_pkg::absq_entry_t pop_data;

    absq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    absq_queue #(
        .AW (QUEUE_AW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    absq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Codes stay within +-127; the divisor shown is never zero.
    `ABSQ_ASSERT_IMPL(a_code_range, m_axis_tvalid, m_axis_tdata[7:0] != 8'h80)
    `ABSQ_ASSERT_IMPL(a_absmax_nonzero, m_axis_tvalid, m_axis_tdata[23:8] != 16'd0)
    `ABSQ_ASSERT_IMPL(a_scale_report, m_axis_tvalid && (m_axis_tuser == absq_pkg::KIND_MEASURE), (m_axis_tdata[7:0] == 8'd0) && m_axis_tlast)
    // The back is busy in the cycle after taking a job.
    `ABSQ_ASSERT_NEXT(a_back_busy, pop_valid && pop_ready, !pop_ready)

endmodule
`default_nettype wire
